FILE: sv/assert_macros.svh
// Assertion macros used by the level detector core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define WPLD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("level detector check failed");
`define WPLD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("level detector invariant failed");
`else
`define WPLD_ASSERT(lbl, prop)
`define WPLD_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: sv/wpld_pkg.sv
// Shared types and constants of the windowed power level detector.
package wpld_pkg;

  // Field widths.
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned SQ_W     = 23;
  localparam int unsigned THR_W    = 23;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned ENERGY_W = 28;
  localparam int unsigned CFG_IDX_W = 2;

  // Default window length.
  localparam int unsigned DEF_WINDOW_LEN = 50;

  // Reset values of the configuration registers.
  localparam logic [THR_W-1:0]    DETECT_THR_RST = 23'd40000;
  localparam logic [THR_W-1:0]    ANNOY_THR_RST  = 23'd150000;
  localparam logic [PERIOD_W-1:0] PERIOD_RST     = 16'd200;

  // Largest value the energy output can show.
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = 28'hFFF_FFFF;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DETECT_THR = 2'd0,
    CFG_ANNOY_THR  = 2'd1,
    CFG_PERIOD     = 2'd2
  } cfg_idx_e;

  // Squares of the entering and the leaving sample.
  typedef struct packed {
    logic [SQ_W-1:0] sq_new;
    logic [SQ_W-1:0] sq_old;
  } sq_pair_t;

  // Square of a centered two's complement sample.
  function automatic logic [SQ_W-1:0] square_of(input logic [SAMPLE_W-1:0] v);
    logic [SAMPLE_W-1:0]   mag;
    logic [2*SAMPLE_W-1:0] prod;
    mag  = v[SAMPLE_W-1] ? (~v + SAMPLE_W'(1)) : v;
    prod = mag * mag;
    return prod[SQ_W-1:0];
  endfunction

endpackage

FILE: sv/wpld_cfg.sv
// Configuration registers with window-scaled thresholds.
module wpld_cfg import wpld_pkg::*; #(
  parameter int unsigned WINDOW_LEN = DEF_WINDOW_LEN
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                  cfg_idx_i,
  input  logic [THR_W-1:0]                      cfg_wdata_i,
  output logic [THR_W+$clog2(WINDOW_LEN+1)-1:0] det_scl_o,
  output logic [THR_W+$clog2(WINDOW_LEN+1)-1:0] ann_scl_o,
  output logic [PERIOD_W-1:0]                   period_o
);

  localparam int unsigned SCL_W = THR_W + $clog2(WINDOW_LEN + 1);
  localparam logic [SCL_W-1:0] DET_SCL_RST = SCL_W'(DETECT_THR_RST) * SCL_W'(WINDOW_LEN);
  localparam logic [SCL_W-1:0] ANN_SCL_RST = SCL_W'(ANNOY_THR_RST) * SCL_W'(WINDOW_LEN);

  logic [SCL_W-1:0]    det_scl_q, det_scl_d;
  logic [SCL_W-1:0]    ann_scl_q, ann_scl_d;
  logic [PERIOD_W-1:0] period_q, period_d;
  logic [SCL_W-1:0]    wdata_scl;

  // Thresholds are stored already multiplied by the window length.
  assign wdata_scl = SCL_W'(cfg_wdata_i) * SCL_W'(WINDOW_LEN);

  // Register write decode; unused indexes are ignored.
  always_comb begin
    det_scl_d = det_scl_q;
    ann_scl_d = ann_scl_q;
    period_d  = period_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DETECT_THR: det_scl_d = wdata_scl;
        CFG_ANNOY_THR:  ann_scl_d = wdata_scl;
        CFG_PERIOD:     period_d  = cfg_wdata_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_scl_q <= DET_SCL_RST;
      ann_scl_q <= ANN_SCL_RST;
      period_q  <= PERIOD_RST;
    end else begin
      det_scl_q <= det_scl_d;
      ann_scl_q <= ann_scl_d;
      period_q  <= period_d;
    end
  end

  assign det_scl_o = det_scl_q;
  assign ann_scl_o = ann_scl_q;
  assign period_o  = period_q;

endmodule

FILE: sv/wpld_front.sv
// Input stage: sample delay line and squares of entering and leaving samples.
module wpld_front import wpld_pkg::*; #(
  parameter int unsigned WINDOW_LEN = DEF_WINDOW_LEN
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sq_pair_t            out_sq_o
);

  logic [SAMPLE_W-1:0] win_q [WINDOW_LEN];
  logic [SAMPLE_W-1:0] centred;
  logic                valid_q, valid_d;
  sq_pair_t            sq_q, sq_d;
  logic                fire;

  // The stage takes a word when empty or when its word leaves this cycle.
  assign in_ready_o = !valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  // Removing the mid-scale offset only flips the top bit.
  assign centred = {~sample_i[SAMPLE_W-1], sample_i[SAMPLE_W-2:0]};

  // Squares of the new sample and of the one that falls out of the window.
  assign sq_d.sq_new = square_of(centred);
  assign sq_d.sq_old = square_of(win_q[WINDOW_LEN-1]);

  always_comb begin
    valid_d = valid_q;
    if (fire) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // Delay line of centered samples, cleared to zero by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_q[i] <= '0;
      end
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (fire) begin
        win_q[0] <= centred;
        for (int i = 1; i < WINDOW_LEN; i++) begin
          win_q[i] <= win_q[i-1];
        end
      end
    end
  end

  // Square register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      sq_q <= sq_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_sq_o    = sq_q;

endmodule

FILE: sv/wpld_core.sv
// Running energy sum, report counter, threshold compares and result register.
module wpld_core import wpld_pkg::*; #(
  parameter int unsigned WINDOW_LEN = DEF_WINDOW_LEN
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  sq_pair_t                              sq_i,
  input  logic [THR_W+$clog2(WINDOW_LEN+1)-1:0] det_scl_i,
  input  logic [THR_W+$clog2(WINDOW_LEN+1)-1:0] ann_scl_i,
  input  logic [PERIOD_W-1:0]                   period_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  detected_o,
  output logic                                  report_valid_o,
  output logic                                  annoying_o,
  output logic [ENERGY_W-1:0]                   window_energy_o
);

  localparam int unsigned SUM_W = SQ_W + $clog2(WINDOW_LEN);
  localparam int unsigned SCL_W = THR_W + $clog2(WINDOW_LEN + 1);
  localparam int unsigned EXT_W = (SUM_W > ENERGY_W) ? SUM_W : ENERGY_W;
  localparam logic [SUM_W-1:0] ENERGY_CAP = SUM_W'(WINDOW_LEN * (1 << (SQ_W - 1)));

  logic [SUM_W-1:0]    energy_q, energy_d;
  logic [PERIOD_W-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                detected_q, detected_d;
  logic                report_q, report_d;
  logic                annoy_q, annoy_d;
  logic [ENERGY_W-1:0] energy_out_q, energy_out_d;
  logic [SCL_W-1:0]    sum_cmp;
  logic [EXT_W-1:0]    sum_ext;
  logic                fire;

  // Output register frees up when empty or when its word is taken.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  // Add the entering square and drop the leaving one.
  assign energy_d = energy_q + SUM_W'(sq_i.sq_new) - SUM_W'(sq_i.sq_old);

  // Report counter: a report restarts the count at one, otherwise it counts up and wraps.
  assign report_d = (cnt_q == period_i);
  assign cnt_d    = report_d ? PERIOD_W'(1) : cnt_q + PERIOD_W'(1);

  // Compare the exact sum against thresholds scaled by the window length.
  assign sum_cmp    = SCL_W'(energy_d);
  assign detected_d = (sum_cmp > det_scl_i);
  assign annoy_d    = report_d && (sum_cmp > ann_scl_i);

  // Saturate the reported energy to the output width.
  assign sum_ext      = EXT_W'(energy_d);
  assign energy_out_d = (sum_ext > EXT_W'(ENERGY_MAX)) ? ENERGY_MAX : sum_ext[ENERGY_W-1:0];

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state and running sums.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q    <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        energy_q <= energy_d;
        cnt_q    <= cnt_d;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      detected_q   <= detected_d;
      report_q     <= report_d;
      annoy_q      <= annoy_d;
      energy_out_q <= energy_out_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign detected_o      = detected_q;
  assign report_valid_o  = report_q;
  assign annoying_o      = annoy_q;
  assign window_energy_o = energy_out_q;

`include "assert_macros.svh"

  // An annoyance verdict only comes with a report.
  `WPLD_ASSERT(a_annoy_needs_report, out_valid_q && annoy_q |-> report_q)
  // A detection needs some energy in the window.
  `WPLD_ASSERT(a_detect_needs_energy, out_valid_q && detected_q |-> energy_out_q != '0)
  // An accepted word always shows up in the result register.
  `WPLD_ASSERT(a_fire_fills_output, fire |=> out_valid_q)
  // The running sum never exceeds a full window of full-scale samples.
  `WPLD_ASSERT(a_energy_bounded, energy_q <= ENERGY_CAP)

endmodule

FILE: sv/windowed_power_level_detector_unit.sv
// A sample passes the square register and then the result register to its result word.
// Throughput: one sample per cycle while out_ready_i is high; the square stage
// and the result register each hold one word, and the energy accumulator updates once per sample.
// Reset clears the sample window, energy sum, report counter and both valid flags,
// and loads the default thresholds and report period.
module windowed_power_level_detector_unit import wpld_pkg::*; #(
  parameter int unsigned WINDOW_LEN = DEF_WINDOW_LEN
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [THR_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [SAMPLE_W-1:0]  sample_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 detected_o,
  output logic                 report_valid_o,
  output logic                 annoying_o,
  output logic [ENERGY_W-1:0]  window_energy_o
);

  localparam int unsigned SCL_W = THR_W + $clog2(WINDOW_LEN + 1);

  logic [SCL_W-1:0]    det_scl;
  logic [SCL_W-1:0]    ann_scl;
  logic [PERIOD_W-1:0] period;
  logic                sq_valid;
  logic                sq_ready;
  sq_pair_t            sq_pair;

  // Configuration registers.
  wpld_cfg #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .det_scl_o  (det_scl),
    .ann_scl_o  (ann_scl),
    .period_o   (period)
  );

  // Delay line and squaring stage.
  wpld_front #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .out_valid_o(sq_valid),
    .out_ready_i(sq_ready),
    .out_sq_o   (sq_pair)
  );

  // Accumulator, compares and result register.
  wpld_core #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (sq_valid),
    .in_ready_o     (sq_ready),
    .sq_i           (sq_pair),
    .det_scl_i      (det_scl),
    .ann_scl_i      (ann_scl),
    .period_i       (period),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .detected_o     (detected_o),
    .report_valid_o (report_valid_o),
    .annoying_o     (annoying_o),
    .window_energy_o(window_energy_o)
  );

endmodule

FILE: tb/windowed_power_level_detector_unit_tb.sv
// Self-checking testbench of the windowed power level detector with its own level predictor.
module windowed_power_level_detector_unit_tb;
  import wpld_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WINDOW_LEN = DEF_WINDOW_LEN;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned PHASE_WORDS = 200;
  localparam int unsigned RANDOM_PHASES = 4;
  localparam logic [THR_W-1:0] THR_TOP = 23'd4194304;
  localparam logic [THR_W-1:0] THR_LOW_BITS = 23'd4194303;
  localparam logic [PERIOD_W-1:0] PERIOD_TOP = 16'd65535;

  // One result word of the block.
  typedef struct packed {
    logic                detected;
    logic                report_valid;
    logic                annoying;
    logic [ENERGY_W-1:0] energy;
  } level_word_t;

  // Shapes of sample bursts used by the random traffic.
  typedef enum int {
    SRC_UNIFORM,
    SRC_CONST,
    SRC_TONE,
    SRC_QUIET
  } src_kind_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [THR_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [SAMPLE_W-1:0]  sample = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 detected;
  logic                 report_valid;
  logic                 annoying;
  logic [ENERGY_W-1:0]  window_energy;

  // Idling controls of the sender and of the receiver, and the error and watchdog counts.
  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned rx_wait = 0;
  int unsigned err_cnt = 0;
  int unsigned quiet_cycles = 0;

  // Expected level words, oldest first.
  level_word_t level_q[$];

  // Predictor state and its copy of the registers.
  int              win_q [WINDOW_LEN];
  int unsigned     win_ptr = 0;
  longint          energy_acc = 0;
  logic [PERIOD_W-1:0] rep_cnt = '0;
  logic [THR_W-1:0]    det_thr = DETECT_THR_RST;
  logic [THR_W-1:0]    ann_thr = ANNOY_THR_RST;
  logic [PERIOD_W-1:0] rep_period = PERIOD_RST;

  windowed_power_level_detector_unit u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .sample_i        (sample),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .detected_o      (detected),
    .report_valid_o  (report_valid),
    .annoying_o      (annoying),
    .window_energy_o (window_energy)
  );

  always #2 clk = ~clk;

  // Updates the window and the report counter for one sample and returns its level word.
  function automatic level_word_t predict_level(input logic [SAMPLE_W-1:0] raw);
    int          centred;
    int          leaving;
    level_word_t w;
    centred = int'(raw) - 2048;
    leaving = win_q[win_ptr];
    energy_acc = energy_acc + longint'(centred * centred) - longint'(leaving * leaving);
    win_q[win_ptr] = centred;
    win_ptr = (win_ptr == WINDOW_LEN - 1) ? 0 : win_ptr + 1;
    w.report_valid = (rep_cnt == rep_period);
    w.annoying = w.report_valid && (energy_acc > longint'(ann_thr) * longint'(WINDOW_LEN));
    rep_cnt = w.report_valid ? PERIOD_W'(1) : rep_cnt + PERIOD_W'(1);
    w.detected = energy_acc > longint'(det_thr) * longint'(WINDOW_LEN);
    w.energy = (energy_acc > longint'(ENERGY_MAX)) ? ENERGY_MAX : ENERGY_W'(energy_acc);
    return w;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [THR_W-1:0] pick_threshold();
    case ($urandom_range(0, 5))
      0: begin
        return '0;
      end
      1: begin
        return THR_TOP;
      end
      2: begin
        return THR_LOW_BITS;
      end
      3: begin
        return THR_W'($urandom_range(0, 300000));
      end
      4: begin
        return THR_W'($urandom_range(30000, 160000));
      end
      default: begin
        return THR_W'($urandom_range(0, 4194304));
      end
    endcase
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_period();
    case ($urandom_range(0, 5))
      0: begin
        return PERIOD_W'(1);
      end
      1: begin
        return PERIOD_W'(2);
      end
      2: begin
        return '0;
      end
      3: begin
        return PERIOD_W'($urandom_range(1, 65535));
      end
      default: begin
        return PERIOD_W'($urandom_range(3, 60));
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (err_cnt < 40) begin
      $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    err_cnt++;
  endtask

  // Offers one sample word, waits for its handshake and records its expected result.
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    int unsigned gap;
    gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= value;
    do @(posedge clk); while (!in_ready);
    level_q.push_back(predict_level(value));
  endtask

  // Stops offering and waits until every expected word has come and the pipeline is empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_DETECT_THR: begin
        det_thr = data;
      end
      CFG_ANNOY_THR: begin
        ann_thr = data;
      end
      CFG_PERIOD: begin
        rep_period = data[PERIOD_W-1:0];
      end
      default: begin
      end
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_burst(input src_kind_e kind, input int unsigned count);
    logic [SAMPLE_W-1:0] level;
    int unsigned         amp;
    level = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? 12'd0 : 12'd4095)
                                 : SAMPLE_W'($urandom_range(0, 4095));
    amp = $urandom_range(0, 2048);
    for (int unsigned i = 0; i < count; i++) begin
      case (kind)
        SRC_CONST: begin
          send_sample(level);
        end
        SRC_TONE: begin
          if (i[0]) begin
            send_sample(SAMPLE_W'(2048 + ((amp > 2047) ? 2047 : amp)));
          end else begin
            send_sample(SAMPLE_W'(2048 - amp));
          end
        end
        SRC_QUIET: begin
          send_sample(SAMPLE_W'(2048 + $urandom_range(0, 64) - 32));
        end
        default: begin
          send_sample(SAMPLE_W'($urandom_range(0, 4095)));
        end
      endcase
    end
  endtask

  // Right after reset the counter is zero, so period zero reports on the first word.
  task automatic test_period_zero_at_reset();
    cfg_write(CFG_PERIOD, '0);
    send_sample(12'd2048);
    send_sample(12'd4095);
    send_sample(12'd0);
    wait_idle();
  endtask

  // A write to the unused index must leave every register as it was.
  task automatic test_unused_index();
    cfg_write(CFG_IDX_UNUSED, 23'h7FFFFF);
    send_sample(12'd1);
    send_sample(12'd4094);
    send_sample(12'd2047);
    wait_idle();
  endtask

  task automatic test_field_extremes();
    logic [SAMPLE_W-1:0] first_vals [12] = '{12'd0, 12'd4095, 12'd1, 12'd4094, 12'd2047,
      12'd2048, 12'd2049, 12'hAAA, 12'h555, 12'd4095, 12'd4095, 12'd0};
    cfg_write(CFG_DETECT_THR, '0);
    cfg_write(CFG_ANNOY_THR, THR_TOP);
    cfg_write(CFG_PERIOD, PERIOD_W'(1));
    foreach (first_vals[i]) send_sample(first_vals[i]);
    wait_idle();
    cfg_write(CFG_DETECT_THR, THR_LOW_BITS);
    cfg_write(CFG_ANNOY_THR, '0);
    cfg_write(CFG_PERIOD, PERIOD_W'(2));
    for (int i = 0; i < 6; i++) begin
      send_sample(i[0] ? 12'd0 : 12'd4095);
    end
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while words keep coming, so the input stalls.
  task automatic test_receiver_hold();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    hold_req = 1'b1;
    send_burst(SRC_UNIFORM, 40);
    wait_idle();
  endtask

  // The sender stops halfway until every expected word has come.
  task automatic test_sender_pause();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_burst(SRC_TONE, 30);
    in_valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    send_burst(SRC_CONST, 30);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned len;
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      cfg_write(CFG_DETECT_THR, pick_threshold());
      cfg_write(CFG_ANNOY_THR, pick_threshold());
      cfg_write(CFG_PERIOD, pick_period());
      if ($urandom_range(0, 2) == 0) begin
        cfg_write(CFG_IDX_UNUSED, THR_W'($urandom_range(0, 8388607)));
      end
      tx_idle_en = (ph % 3 != 2);
      rx_idle_en = (ph % 3 != 2);
      sent = 0;
      while (sent < PHASE_WORDS) begin
        len = $urandom_range(20, 70);
        send_burst(src_kind_e'($urandom_range(0, 3)), len);
        sent += len;
      end
      wait_idle();
    end
  endtask

  // Period lowered below the counter: the count keeps climbing and no report comes.
  task automatic test_period_lowered();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    cfg_write(CFG_PERIOD, PERIOD_TOP);
    while (rep_cnt <= 20) send_sample(SAMPLE_W'($urandom_range(0, 4095)));
    wait_idle();
    cfg_write(CFG_PERIOD, PERIOD_W'(5));
    send_burst(SRC_UNIFORM, 30);
    wait_idle();
  endtask

  // Receiver: random stalls, and one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      rx_wait = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
      rx_wait = pick_gap() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    level_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (level_q.size() == 0) begin
        report_mismatch("unexpected word", window_energy, 0);
      end else begin
        want = level_q.pop_front();
        if (detected !== want.detected) begin
          report_mismatch("detected", detected, want.detected);
        end
        if (report_valid !== want.report_valid) begin
          report_mismatch("report_valid", report_valid, want.report_valid);
        end
        if (annoying !== want.annoying) begin
          report_mismatch("annoying", annoying, want.annoying);
        end
        if (window_energy !== want.energy) begin
          report_mismatch("window_energy", window_energy, want.energy);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL windowed_power_level_detector_unit");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_period_zero_at_reset();
    test_unused_index();
    test_field_extremes();
    test_receiver_hold();
    test_sender_pause();
    test_random_traffic();
    test_period_lowered();
    wait_idle();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS windowed_power_level_detector_unit");
    end else begin
      $display("FAIL windowed_power_level_detector_unit");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/wpld_pkg.sv
sv/wpld_cfg.sv
sv/wpld_front.sv
sv/wpld_core.sv
sv/windowed_power_level_detector_unit.sv
tb/windowed_power_level_detector_unit_tb.sv
